// ===== design/escs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escs_pkg
// Shared types and constants for the escaped substring extractor.
// ----------------------------------------------------------------------------
package escs_pkg;

    localparam int CAP_W            = 11;
    localparam int MAX_CAPACITY_DEF = 1024;
    localparam int QUEUE_DEPTH      = 4;
    localparam int ADDR_W           = 4;

    localparam logic [7:0]       SEP_RESET = 8'd44;
    localparam logic [7:0]       ALT_RESET = 8'd0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_SEPARATOR = 2'd0;
    localparam logic [1:0] REG_ALTERNATE = 2'd1;
    localparam logic [1:0] REG_DECODE    = 2'd2;
    localparam logic [1:0] REG_CAPACITY  = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CODE_TAB  = 8'd9;
    localparam logic [7:0] CODE_BS   = 8'd8;
    localparam logic [7:0] CODE_CR   = 8'd13;
    localparam logic [7:0] CODE_LF   = 8'd10;

    typedef enum logic [7:0] {
        PH_NORMAL     = 8'b0000_0001,
        PH_AFTER_OPEN = 8'b0000_0010,
        PH_GROUP      = 8'b0000_0100,
        PH_GROUP_BSL  = 8'b0000_1000,
        PH_RAW_ESC    = 8'b0001_0000,
        PH_ESC        = 8'b0010_0000,
        PH_OCT1       = 8'b0100_0000,
        PH_OCT2       = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]       sep;
        logic [7:0]       alt;
        logic             decode;
        logic [CAP_W-1:0] cap;
        logic             cap_load;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       stopped_at_separator;
        logic       terminator_written;
    } result_t;

    typedef struct packed {
        logic       push0;
        logic       push1;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [7:0] decode_letter(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c == CH_T)      r = CODE_TAB;
            else if (c == CH_B) r = CODE_BS;
            else if (c == CH_R) r = CODE_CR;
            else if (c == CH_N) r = CODE_LF;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/escs_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escs_cfg
// APB register file: separators, decode mode and buffer capacity.
// ----------------------------------------------------------------------------
module escs_cfg #(
    parameter int MAX_CAPACITY = escs_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [escs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output escs_pkg::cfg_t                  cfg
);
    import escs_pkg::*;

    localparam int CAP_MAX_CODE = (1 << CAP_W) - 1;
    localparam int CAP_LIMIT    = (MAX_CAPACITY > CAP_MAX_CODE) ? CAP_MAX_CODE : MAX_CAPACITY;

    logic [7:0]       sep_reg;
    logic [7:0]       alt_reg;
    logic             decode_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // saturate capacity to the build limit
    always_comb
    begin
        if (pwdata[CAP_W-1:0] > CAP_W'(CAP_LIMIT))
            cap_next = CAP_W'(CAP_LIMIT);
        else
            cap_next = pwdata[CAP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= SEP_RESET;
            alt_reg    <= ALT_RESET;
            decode_reg <= 1'b0;
            cap_reg    <= (CAP_RESET > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : CAP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SEPARATOR: sep_reg    <= pwdata[7:0];
                REG_ALTERNATE: alt_reg    <= pwdata[7:0];
                REG_DECODE:    decode_reg <= pwdata[0];
                REG_CAPACITY:  cap_reg    <= cap_next;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEPARATOR: prdata = {24'd0, sep_reg};
            REG_ALTERNATE: prdata = {24'd0, alt_reg};
            REG_DECODE:    prdata = {31'd0, decode_reg};
            REG_CAPACITY:  prdata = {{(32-CAP_W){1'b0}}, cap_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.sep      = sep_reg;
        cfg.alt      = alt_reg;
        cfg.decode   = decode_reg;
        cfg.cap      = (wr_en && reg_idx == REG_CAPACITY) ? cap_next : cap_reg;
        cfg.cap_load = wr_en && (reg_idx == REG_CAPACITY);
    end

endmodule
`default_nettype wire

// ===== design/escs_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escs_parse
// Field parser: one character per cycle while take is high, up to two results pushed.
// ----------------------------------------------------------------------------
module escs_parse #(
    parameter int MAX_CAPACITY = escs_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire escs_pkg::cfg_t            cfg,
    input  wire logic                      take,
    input  wire logic [7:0]                in_char,
    output escs_pkg::push_t                push,
    output logic [escs_pkg::CAP_W-1:0]     room
);
    import escs_pkg::*;

    localparam int CAP_MAX_CODE = (1 << CAP_W) - 1;
    localparam int CAP_LIMIT    = (MAX_CAPACITY > CAP_MAX_CODE) ? CAP_MAX_CODE : MAX_CAPACITY;
    localparam logic [CAP_W-1:0] ROOM_RESET =
        (CAP_RESET > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : CAP_RESET;

    phase_t           phase_reg, phase_next;
    logic             bracket_reg, bracket_next;
    logic [7:0]       oct_reg, oct_next;
    logic [CAP_W-1:0] room_reg, room_next;

    logic             is_zero, is_sep, is_oct;
    logic [2:0]       digit;
    logic             emit0_req, emit1_req, end_req;
    logic [7:0]       emit0_byte, emit1_byte;
    logic             do_normal, do_body, do_group;
    logic             grant0, grant1;
    logic [CAP_W-1:0] room_mid, room_end;
    logic             gb_normal, gb_body;
    phase_t           ph_a;
    logic             br_a;

    assign is_zero = (in_char == CH_NUL);
    assign is_sep  = is_zero || (in_char == cfg.sep) || (in_char == cfg.alt);
    assign is_oct  = (in_char >= CH_ZERO) && (in_char <= CH_SEVEN);
    assign digit   = in_char[2:0];

    // first stage of the step: what the current phase does with the character
    always_comb
    begin
        ph_a       = phase_reg;
        br_a       = bracket_reg;
        oct_next   = oct_reg;
        emit0_req  = 1'b0;
        emit0_byte = in_char;
        end_req    = 1'b0;
        do_normal  = 1'b0;
        do_body    = 1'b0;
        do_group   = 1'b0;
        case (phase_reg)
            PH_AFTER_OPEN:
            begin
                if (is_zero) end_req = 1'b1;
                else
                begin
                    ph_a    = PH_NORMAL;
                    do_body = 1'b1;
                end
            end
            PH_GROUP: do_group = 1'b1;
            PH_GROUP_BSL:
            begin
                if (in_char == CH_CLOSE)
                begin
                    emit0_req = 1'b1;
                    ph_a      = PH_GROUP;
                end
                else do_group = 1'b1;
            end
            PH_RAW_ESC:
            begin
                if (is_zero) end_req = 1'b1;
                else
                begin
                    ph_a      = PH_NORMAL;
                    emit0_req = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (is_zero) end_req = 1'b1;
                else if (is_oct)
                begin
                    oct_next = {5'd0, digit};
                    ph_a     = PH_OCT1;
                end
                else
                begin
                    ph_a       = PH_NORMAL;
                    emit0_req  = 1'b1;
                    emit0_byte = decode_letter(in_char);
                end
            end
            PH_OCT1, PH_OCT2:
            begin
                if (is_oct && phase_reg == PH_OCT1)
                begin
                    oct_next = {oct_reg[4:0], digit};
                    ph_a     = PH_OCT2;
                end
                else if (is_oct)
                begin
                    emit0_req  = 1'b1;
                    emit0_byte = {oct_reg[4:0], digit};
                    oct_next   = 8'd0;
                    ph_a       = PH_NORMAL;
                end
                else
                begin
                    // short escape: flush the value, then rescan the character
                    emit0_req  = 1'b1;
                    emit0_byte = oct_reg;
                    oct_next   = 8'd0;
                    ph_a       = PH_NORMAL;
                    do_normal  = 1'b1;
                end
            end
            default: do_normal = 1'b1;
        endcase
    end

    // second stage: normal scan, body and group handling
    always_comb
    begin
        phase_next   = ph_a;
        bracket_next = br_a;
        emit1_req    = 1'b0;
        emit1_byte   = in_char;
        gb_normal    = 1'b0;
        gb_body      = do_body;
        if (do_normal)
        begin
            if (is_sep) gb_normal = 1'b1;
            else if (in_char == CH_OPEN)
            begin
                bracket_next = 1'b1;
                if (!cfg.decode)
                begin
                    emit1_req  = 1'b1;
                    phase_next = PH_GROUP;
                end
                else phase_next = PH_AFTER_OPEN;
            end
            else gb_body = 1'b1;
        end
        if (gb_body)
        begin
            if (br_a && in_char == CH_CLOSE) bracket_next = 1'b0;
            else if (in_char == CH_BSL)
            begin
                if (cfg.decode) phase_next = PH_ESC;
                else
                begin
                    emit1_req  = 1'b1;
                    phase_next = PH_RAW_ESC;
                end
            end
            else emit1_req = 1'b1;
        end
        if (do_group && !is_zero)
        begin
            emit1_req = 1'b1;
            if (in_char == CH_CLOSE)
            begin
                bracket_next = 1'b0;
                phase_next   = PH_NORMAL;
            end
            else if (in_char == CH_BSL) phase_next = PH_GROUP_BSL;
            else phase_next = PH_GROUP;
        end
    end

    logic end_all;
    assign end_all = end_req || gb_normal || (do_group && is_zero);

    // room accounting: drop bytes once only the closing zero's slot is left
    always_comb
    begin
        grant0   = emit0_req && (room_reg > CAP_W'(1));
        room_mid = grant0 ? room_reg - CAP_W'(1) : room_reg;
        grant1   = emit1_req && (room_mid > CAP_W'(1));
        room_end = grant1 ? room_mid - CAP_W'(1) : room_mid;
    end

    result_t r_b0, r_b1, r_end;
    always_comb
    begin
        r_b0  = '{out_byte: emit0_byte, byte_valid: 1'b1, last: 1'b0,
                  stopped_at_separator: 1'b0, terminator_written: 1'b0};
        r_b1  = '{out_byte: emit1_byte, byte_valid: 1'b1, last: 1'b0,
                  stopped_at_separator: 1'b0, terminator_written: 1'b0};
        r_end = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                  stopped_at_separator: !is_zero,
                  terminator_written: (room_end != '0)};
        push.res0  = grant0 ? r_b0 : (grant1 ? r_b1 : r_end);
        push.res1  = (grant0 && grant1) ? r_b1 : r_end;
        push.push0 = take && (grant0 || grant1 || end_all);
        push.push1 = take && (grant0 || grant1) && (end_all || (grant0 && grant1));
    end

    always_comb
    begin
        room_next = room_reg;
        if (cfg.cap_load)
            room_next = cfg.cap;
        else if (take)
            room_next = end_all ? cfg.cap : room_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NORMAL;
            bracket_reg <= 1'b0;
            oct_reg     <= 8'd0;
            room_reg    <= ROOM_RESET;
        end
        else
        begin
            room_reg <= room_next;
            if (take)
            begin
                // field end returns all parse state to its start values
                phase_reg   <= end_all ? PH_NORMAL : phase_next;
                bracket_reg <= end_all ? 1'b0 : bracket_next;
                oct_reg     <= end_all ? 8'd0 : oct_next;
            end
        end
    end

    assign room = room_reg;

endmodule
`default_nettype wire

// ===== design/escs_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escs_outq
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module escs_outq (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire escs_pkg::push_t push,
    input  wire logic      pop,
    output logic           nonempty,
    output logic           room_two,
    output escs_pkg::result_t head,
    output logic [$clog2(escs_pkg::QUEUE_DEPTH):0] count
);
    import escs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       n_push;
    logic [PTR_W-1:0] wptr_plus1;

    assign n_push     = {1'b0, push.push0} + {1'b0, push.push1};
    assign wptr_plus1 = wptr_reg + PTR_W'(1);
    assign wptr_next  = wptr_reg + PTR_W'(n_push);
    assign cnt_next   = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.push0) entry_reg[wptr_reg]   <= push.res0;
        if (push.push1) entry_reg[wptr_plus1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            cnt_reg  <= cnt_next;
            if (pop) rptr_reg <= rptr_reg + PTR_W'(1);
        end
    end

    assign nonempty = (cnt_reg != '0);
    assign room_two = (cnt_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign head     = entry_reg[rptr_reg];
    assign count    = cnt_reg;

endmodule
`default_nettype wire

// ===== design/escaped_substring_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_substring_extractor
// Cuts a character stream into fields, handling brackets and escapes.
// ----------------------------------------------------------------------------
// Output: a result is written into the result queue when its item is taken.
// Throughput: one item per cycle; the four-entry result queue absorbs items
// that give two results and short output stalls, and the input stalls while
// fewer than two queue slots are free.
// Reset: registers return to their reset values, parse state to the start of
// a field, and the result queue empties; no clearing pass is needed.
// ----------------------------------------------------------------------------
module escaped_substring_extractor #(
    parameter int MAX_CAPACITY = escs_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [escs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // character input
    input  wire logic                        char_valid,
    output logic                             char_stall,
    input  wire logic [7:0]                  in_char,
    // result output
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             last,
    output logic                             stopped_at_separator,
    output logic                             terminator_written
);
    import escs_pkg::*;

    cfg_t             cfg;
    push_t            push;
    result_t          head;
    logic             take, pop, nonempty, room_two;
    logic [CAP_W-1:0] room;
    logic [$clog2(QUEUE_DEPTH):0] q_count;

    assign pready = 1'b1;

    escs_cfg #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cfg    (cfg)
    );

    // Stall only on queue space, so an item is never taken without room for
    // both of its possible results.
    assign char_stall = !room_two;
    assign take       = char_valid && !char_stall;

    escs_parse #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .take   (take),
        .in_char(in_char),
        .push   (push),
        .room   (room)
    );

    // Hold the head result until the consumer takes it.
    assign pop = nonempty && !res_stall;

    escs_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .nonempty(nonempty),
        .room_two(room_two),
        .head    (head),
        .count   (q_count)
    );

    assign res_valid            = nonempty;
    assign out_byte             = head.out_byte;
    assign byte_valid           = head.byte_valid;
    assign last                 = head.last;
    assign stopped_at_separator = head.stopped_at_separator;
    assign terminator_written   = head.terminator_written;

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QUEUE_DEPTH) + 1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // a field end never carries a data byte
    a_last_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last) |-> (!byte_valid && out_byte == 8'd0))
        else $error("field end carries a byte");

    // room never exceeds the configured capacity
    a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.cap_load |-> (room <= cfg.cap))
        else $error("room above capacity");

    // after a field end is pushed the room reloads from capacity
    a_room_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ((push.push0 && push.res0.last) || (push.push1 && push.res1.last))
         && !cfg.cap_load) |=> (room == $past(cfg.cap)))
        else $error("room not reloaded at field end");

endmodule
`default_nettype wire
